// ===== hw/rtl/rs_enc_pkg.sv =====
// Shared types, constants and GF(256) helper functions for the RS(255,223) encoder.
// Constant tables (basis matrices, generator coefficients) are built at elaboration.
// No dependencies.
package rs_enc_pkg;

    localparam int unsigned DATA_LEN   = 223;
    localparam int unsigned PARITY_LEN = 32;
    localparam int unsigned FIRST_ROOT = 112;
    localparam int unsigned ROOT_STEP  = 11;
    localparam int unsigned CNT_W      = 8;
    localparam int unsigned IDX_W      = 5;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [8:0]       FIELD_POLY = 9'h187;
    localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(DATA_LEN - 1);
    localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(PARITY_LEN - 1);

    // column b holds the image of basis bit b
    typedef logic [7:0][7:0]            t_mat;
    typedef logic [PARITY_LEN-1:0][7:0] t_rem;

    typedef struct packed {
        logic [7:0] sym;   // conventional basis
        logic       last;  // closes the codeword
    } t_q_entry;

    function automatic logic [7:0] f_gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] x;
        logic [7:0] r;
        x = {1'b0, a};
        r = '0;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) r = r ^ x[7:0];
            x = {x[7:0], 1'b0};
            if (x[8]) x = x ^ FIELD_POLY;
        end
        return r;
    endfunction

    function automatic logic [7:0] f_alpha_pow(input int unsigned e);
        logic [7:0] r;
        r = 8'h01;
        for (int unsigned k = 0; k < e; k++) r = f_gf_mul(r, 8'h02);
        return r;
    endfunction

    function automatic logic f_trace(input logic [7:0] x);
        logic [7:0] t;
        logic [7:0] v;
        t = '0;
        v = x;
        for (int k = 0; k < 8; k++) begin
            t = t ^ v;
            v = f_gf_mul(v, v);
        end
        return t[0];
    endfunction

    // dual bit i = Tr(alpha^i * y), bit 0 sits in the MSB
    function automatic logic [7:0] f_c2d_calc(input logic [7:0] y);
        logic [7:0] z;
        z = '0;
        for (int i = 0; i < 8; i++) z[7-i] = f_trace(f_gf_mul(f_alpha_pow(i), y));
        return z;
    endfunction

    function automatic t_mat f_c2d_mat();
        t_mat m;
        for (int b = 0; b < 8; b++) m[b] = f_c2d_calc(8'h01 << b);
        return m;
    endfunction

    // apply a GF(2)-linear map given by its columns
    function automatic logic [7:0] f_lin(input t_mat m, input logic [7:0] x);
        logic [7:0] r;
        r = '0;
        for (int b = 0; b < 8; b++) begin
            if (x[b]) r = r ^ m[b];
        end
        return r;
    endfunction

    function automatic t_mat f_d2c_mat(input t_mat c2d);
        t_mat       m;
        logic [7:0] target;
        logic [7:0] y;
        m = '0;
        for (int b = 0; b < 8; b++) begin
            target = 8'h01 << b;
            for (int k = 0; k < 256; k++) begin
                y = 8'(k);
                if (f_lin(c2d, y) == target) m[b] = y;
            end
        end
        return m;
    endfunction

    function automatic t_rem f_gen_coef();
        logic [PARITY_LEN:0][7:0] g;
        logic [7:0]               root;
        logic [7:0]               step;
        g    = '0;
        g[0] = 8'h01;
        root = f_alpha_pow(ROOT_STEP * FIRST_ROOT);
        step = f_alpha_pow(ROOT_STEP);
        for (int r = 0; r < PARITY_LEN; r++) begin
            for (int k = r + 1; k > 0; k--) g[k] = g[k-1] ^ f_gf_mul(root, g[k]);
            g[0] = f_gf_mul(root, g[0]);
            root = f_gf_mul(root, step);
        end
        return g[PARITY_LEN-1:0];
    endfunction

    localparam t_mat C2D_MAT  = f_c2d_mat();
    localparam t_mat D2C_MAT  = f_d2c_mat(C2D_MAT);
    localparam t_rem GEN_COEF = f_gen_coef();

endpackage

// ===== hw/rtl/rs_enc_front.sv =====
// Front end: accept dual-basis bytes, convert to conventional basis, mark codeword end.
// Depends on rs_enc_pkg.
module rs_enc_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_data_valid,
    output logic                 o_data_ready,
    input  logic [7:0]           i_data_byte,
    output logic                 o_push,
    input  logic                 i_push_ready,
    output rs_enc_pkg::t_q_entry o_push_entry
);
    logic [rs_enc_pkg::CNT_W-1:0] r_byte_count;
    logic [rs_enc_pkg::CNT_W-1:0] n_byte_count;
    logic                         w_last;

    assign o_data_ready = i_push_ready;
    assign o_push       = i_data_valid && i_push_ready;
    assign w_last       = (r_byte_count == rs_enc_pkg::LAST_COUNT);

    assign o_push_entry.sym  = rs_enc_pkg::f_lin(rs_enc_pkg::D2C_MAT, i_data_byte);
    assign o_push_entry.last = w_last;

    always_comb begin
        n_byte_count = r_byte_count;
        if (o_push) begin
            n_byte_count = w_last ? '0 : r_byte_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
        end else begin
            r_byte_count <= n_byte_count;
        end
    end
endmodule

// ===== hw/rtl/rs_enc_queue.sv =====
// Two-entry queue between front end and LFSR back end.
// Depends on rs_enc_pkg.
module rs_enc_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    output logic                 o_push_ready,
    input  rs_enc_pkg::t_q_entry i_push_entry,
    output logic                 o_pop_valid,
    input  logic                 i_pop,
    output rs_enc_pkg::t_q_entry o_pop_entry
);
    rs_enc_pkg::t_q_entry r_mem [rs_enc_pkg::QUEUE_DEPTH];
    logic                 r_wr_ptr;
    logic                 r_rd_ptr;
    logic [1:0]           r_count;
    logic [1:0]           n_count;

    assign o_push_ready = (r_count != 2'(rs_enc_pkg::QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_entry  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) n_count = r_count + 2'd1;
        if (!i_push && i_pop) n_count = r_count - 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_push_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= ~r_wr_ptr;
            if (i_pop)  r_rd_ptr <= ~r_rd_ptr;
            r_count <= n_count;
        end
    end
endmodule

// ===== hw/rtl/rs_enc_back.sv =====
// Back end: 32-stage LFSR divide by g(x) and a parity shift-out register.
// Depends on rs_enc_pkg.
module rs_enc_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_pop_valid,
    output logic                              o_pop,
    input  rs_enc_pkg::t_q_entry              i_pop_entry,
    output logic                              o_parity_valid,
    input  logic                              i_parity_ready,
    output logic [7:0]                        o_parity_byte,
    output logic [rs_enc_pkg::IDX_W-1:0]      o_parity_index,
    output logic                              o_last_parity
);
    rs_enc_pkg::t_rem             r_rem;
    rs_enc_pkg::t_rem             n_rem;
    rs_enc_pkg::t_rem             r_shift;
    logic                         r_active;
    logic [rs_enc_pkg::IDX_W-1:0] r_idx;
    logic [7:0]                   w_fb;
    logic                         w_out_fire;
    logic                         w_out_done;
    logic                         w_can_load;

    assign w_out_fire = r_active && i_parity_ready;
    assign w_out_done = w_out_fire && (r_idx == rs_enc_pkg::LAST_INDEX);
    assign w_can_load = !r_active || w_out_done;
    // a closing byte waits until the previous parity block has drained
    assign o_pop      = i_pop_valid && (!i_pop_entry.last || w_can_load);

    assign w_fb = i_pop_entry.sym ^ r_rem[rs_enc_pkg::PARITY_LEN-1];

    always_comb begin
        n_rem[0] = rs_enc_pkg::f_gf_mul(w_fb, rs_enc_pkg::GEN_COEF[0]);
        for (int j = 1; j < rs_enc_pkg::PARITY_LEN; j++) begin
            n_rem[j] = r_rem[j-1] ^ rs_enc_pkg::f_gf_mul(w_fb, rs_enc_pkg::GEN_COEF[j]);
        end
    end

    assign o_parity_valid = r_active;
    assign o_parity_byte  = rs_enc_pkg::f_lin(rs_enc_pkg::C2D_MAT,
                                              r_shift[rs_enc_pkg::PARITY_LEN-1]);
    assign o_parity_index = r_idx;
    assign o_last_parity  = (r_idx == rs_enc_pkg::LAST_INDEX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem    <= '0;
            r_active <= 1'b0;
            r_idx    <= '0;
        end else begin
            if (o_pop) begin
                r_rem <= i_pop_entry.last ? '0 : n_rem;
            end
            if (o_pop && i_pop_entry.last) begin
                r_active <= 1'b1;
                r_idx    <= '0;
            end else if (w_out_fire) begin
                r_active <= !w_out_done;
                r_idx    <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_pop_entry.last) begin
            r_shift <= n_rem;
        end else if (w_out_fire) begin
            r_shift <= {r_shift[rs_enc_pkg::PARITY_LEN-2:0], 8'h00};
        end
    end
endmodule

// ===== hw/rtl/ccsds_rs_255_223_encoder_core.sv =====
// A closing byte is registered in the queue, then its remainder loads the parity shifter.
// Throughput: 1 data byte per cycle; 32 parity bytes leave at 1 per cycle while accepted,
// overlapped with new data, so a closing byte stalls only while the prior block drains.
// Reset: i_rst_n synchronous active low clears the LFSR, byte counter, queue and output.
// Depends on rs_enc_pkg, rs_enc_front, rs_enc_queue, rs_enc_back.
module ccsds_rs_255_223_encoder_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // data byte request channel
    input  logic       i_data_valid,
    output logic       o_data_ready,
    input  logic [7:0] i_data_byte,
    // parity request channel
    output logic       o_parity_valid,
    input  logic       i_parity_ready,
    output logic [7:0] o_parity_byte,
    output logic [4:0] o_parity_index,
    output logic       o_last_parity
);
    logic                 w_push;
    logic                 w_push_ready;
    rs_enc_pkg::t_q_entry w_push_entry;
    logic                 w_pop_valid;
    logic                 w_pop;
    rs_enc_pkg::t_q_entry w_pop_entry;

    // convert basis and tag the DATA_LEN-th byte of each codeword
    rs_enc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_data_valid (i_data_valid),
        .o_data_ready (o_data_ready),
        .i_data_byte  (i_data_byte),
        .o_push       (w_push),
        .i_push_ready (w_push_ready),
        .o_push_entry (w_push_entry)
    );

    // decouple the front from LFSR stalls
    rs_enc_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .o_push_ready (w_push_ready),
        .i_push_entry (w_push_entry),
        .o_pop_valid  (w_pop_valid),
        .i_pop        (w_pop),
        .o_pop_entry  (w_pop_entry)
    );

    // advance LFSR, snapshot remainder on codeword end, shift parity out
    rs_enc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pop_valid    (w_pop_valid),
        .o_pop          (w_pop),
        .i_pop_entry    (w_pop_entry),
        .o_parity_valid (o_parity_valid),
        .i_parity_ready (i_parity_ready),
        .o_parity_byte  (o_parity_byte),
        .o_parity_index (o_parity_index),
        .o_last_parity  (o_last_parity)
    );
endmodule

// ===== hw/rtl/rs_enc_chk.sv =====
// Port-level checker for the RS(255,223) encoder core, with its bind statement.
// Depends on ccsds_rs_255_223_encoder_core.
module rs_enc_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_parity_valid,
    input logic       i_parity_ready,
    input logic [7:0] o_parity_byte,
    input logic [4:0] o_parity_index,
    input logic       o_last_parity
);
    // reset drops any pending parity
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_parity_valid)
        else $error("parity valid after reset");

    // stalled parity request holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_parity_valid && !i_parity_ready |=>
            o_parity_valid && $stable(o_parity_byte) && $stable(o_parity_index))
        else $error("parity request changed while stalled");

    // last flag marks exactly the final index
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_parity_valid |-> (o_last_parity == (o_parity_index == 5'd31)))
        else $error("last flag mismatch");

    // a parity block never breaks up: the next index follows at once
    a_block_contig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_parity_valid && i_parity_ready && !o_last_parity |=>
            o_parity_valid && (o_parity_index == $past(o_parity_index) + 5'd1))
        else $error("parity block gap or index skip");
endmodule

bind ccsds_rs_255_223_encoder_core rs_enc_chk u_rs_enc_chk (.*);
